// ===== rtl/fdl_pkg.sv =====
// shared constants and types for the feedback delay with damping filter
package fdl_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int CTRL_W      = 16;
    localparam int COEF_W      = 24;
    localparam int STATE_W     = 48;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIX   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_B0    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_B1    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_B2    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_A1    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_A2    = 4'd7;

    // register reset values
    localparam int                DELAY_RST = 44100;
    localparam logic [CTRL_W-1:0] GAIN_RST  = 16'd19661;
    localparam logic [CTRL_W-1:0] MIX_RST   = 16'd16384;
    localparam logic [COEF_W-1:0] B0_RST    = 24'd1048576;
    localparam logic [COEF_W-1:0] COEF_ZERO = 24'd0;

    // filter state saturation limits
    localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ST_MIN = -ST_MAX - 64'sd1;

    // rounding offsets
    localparam logic signed [63:0] RND_15 = 64'sd16384;
    localparam logic signed [63:0] RND_19 = 64'sd524288;
    localparam logic signed [63:0] RND_16 = 64'sd32768;

    // gain, mix and filter coefficients as held by the register file
    typedef struct packed {
        logic [CTRL_W-1:0] gain;
        logic [CTRL_W-1:0] mix;
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } t_coefs;

endpackage

// ===== rtl/fdl_cfg.sv =====
// configuration registers and reduction of the delay distance modulo the depth
module fdl_cfg #(
    parameter int DELAY_DEPTH = 65536,
    localparam int IDX_W = $clog2(DELAY_DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output fdl_pkg::t_coefs                    o_coefs,
    output logic [IDX_W-1:0]                   o_dist,
    output logic                               o_busy
);

    // quotient by reciprocal multiply and shift, exact for every 16-bit distance
    localparam int QSH   = fdl_pkg::CTRL_W + IDX_W;
    localparam int RCP_W = fdl_pkg::CTRL_W + 2;
    localparam int QP_W  = fdl_pkg::CTRL_W + RCP_W;
    localparam int RP_W  = fdl_pkg::CTRL_W + IDX_W + 1;
    localparam logic [63:0] RECIP_L =
        ((64'd1 << QSH) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH);
    localparam logic [RCP_W-1:0] RECIP    = RCP_W'(RECIP_L);
    localparam logic [IDX_W:0]   DEPTH_R  = (IDX_W + 1)'(DELAY_DEPTH);
    localparam logic [IDX_W-1:0] DIST_RST = IDX_W'(fdl_pkg::DELAY_RST % DELAY_DEPTH);

    fdl_pkg::t_coefs                r_coefs;
    logic [IDX_W-1:0]               r_dist;
    logic                           r_busy;
    logic                           r_phase;
    logic [fdl_pkg::CTRL_W-1:0]     r_val;
    logic [fdl_pkg::CTRL_W-1:0]     r_quo;
    logic                           w_wr;
    logic [QP_W-1:0]                w_qprod;
    logic [QP_W-1:0]                w_qshift;
    logic [RP_W-1:0]                w_back;
    logic [RP_W-1:0]                w_rem;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid & o_cfg_ready;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.gain <= fdl_pkg::GAIN_RST;
            r_coefs.mix  <= fdl_pkg::MIX_RST;
            r_coefs.b0   <= fdl_pkg::B0_RST;
            r_coefs.b1   <= fdl_pkg::COEF_ZERO;
            r_coefs.b2   <= fdl_pkg::COEF_ZERO;
            r_coefs.a1   <= fdl_pkg::COEF_ZERO;
            r_coefs.a2   <= fdl_pkg::COEF_ZERO;
        end else if (w_wr) begin
            unique case (i_cfg_index)
                fdl_pkg::REG_DELAY: ;
                fdl_pkg::REG_GAIN:  r_coefs.gain <= i_cfg_data[fdl_pkg::CTRL_W-1:0];
                fdl_pkg::REG_MIX:   r_coefs.mix  <= i_cfg_data[fdl_pkg::CTRL_W-1:0];
                fdl_pkg::REG_B0:    r_coefs.b0   <= i_cfg_data;
                fdl_pkg::REG_B1:    r_coefs.b1   <= i_cfg_data;
                fdl_pkg::REG_B2:    r_coefs.b2   <= i_cfg_data;
                fdl_pkg::REG_A1:    r_coefs.a1   <= i_cfg_data;
                fdl_pkg::REG_A2:    r_coefs.a2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase 0 forms the quotient, phase 1 subtracts quotient times depth
    assign w_qprod  = {{RCP_W{1'b0}}, r_val} * {{fdl_pkg::CTRL_W{1'b0}}, RECIP};
    assign w_qshift = w_qprod >> QSH;
    assign w_back   = {{(IDX_W + 1){1'b0}}, r_quo} * {{fdl_pkg::CTRL_W{1'b0}}, DEPTH_R};
    assign w_rem    = {{(IDX_W + 1){1'b0}}, r_val} - w_back;

    // distance modulo depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_val   <= '0;
            r_quo   <= '0;
            r_dist  <= DIST_RST;
        end else if (w_wr && i_cfg_index == fdl_pkg::REG_DELAY) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_val   <= i_cfg_data[fdl_pkg::CTRL_W-1:0];
        end else if (r_busy) begin
            r_phase <= 1'b1;
            if (!r_phase) begin
                r_quo <= w_qshift[fdl_pkg::CTRL_W-1:0];
            end else begin
                r_busy <= 1'b0;
                r_dist <= w_rem[IDX_W-1:0];
            end
        end
    end

    assign o_coefs = r_coefs;
    assign o_dist  = r_dist;
    assign o_busy  = r_busy;

endmodule

// ===== rtl/fdl_mem.sv =====
// single-port-write, single-port-read delay memory with registered read data
module fdl_mem #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/feedback_delay_with_lowpass.sv =====
// feedback echo with biquad damping in the loop, one audio channel
//
//  channel   direction  beat payload
//  s_axis    in         sample_in, signed SAMPLE_BITS, zero padded to bytes
//  m_axis    out        sample_out, signed SAMPLE_BITS, zero padded to bytes
//  cfg       in         register index and write data
//
//  the next sample is taken only once the last one has passed through its steps:
//  one delay memory read, the feedback multiply, the three feed-forward
//  multiplies, the state and output multiplies, and the saturating adds between.
//  reset leaves the block ready at once; unwritten delay entries read as zero by
//  tracking how far the write index has filled the memory, so no clearing pass.
//  a write of delay_samples runs a two-step reciprocal reduction, input stalls meanwhile.
//  the last step holds while a finished sample still waits on m_axis.
module feedback_delay_with_lowpass #(
    parameter int DELAY_DEPTH = 65536,
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [TDATA_W-1:0]              s_axis_tdata,   // sample_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [TDATA_W-1:0]              m_axis_tdata,   // sample_out
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int IDX_W = $clog2(DELAY_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DELAY_DEPTH);
    localparam logic [IDX_W-1:0] WI_LAST  = IDX_W'(DELAY_DEPTH - 1);
    localparam logic signed [63:0] SMP_MAX = (64'sd1 <<< (S - 1)) - 64'sd1;
    localparam logic signed [63:0] SMP_MIN = -SMP_MAX - 64'sd1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_W    = 3'd2;
    localparam logic [2:0] ST_B    = 3'd3;
    localparam logic [2:0] ST_Y    = 3'd4;
    localparam logic [2:0] ST_A    = 3'd5;
    localparam logic [2:0] ST_S    = 3'd6;

    function automatic logic signed [S-1:0] sat_smp(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
        return c[S-1:0];
    endfunction

    function automatic logic signed [fdl_pkg::STATE_W-1:0] sat_st(
        input logic signed [63:0] v
    );
        logic signed [63:0] c;
        c = (v > fdl_pkg::ST_MAX) ? fdl_pkg::ST_MAX
          : ((v < fdl_pkg::ST_MIN) ? fdl_pkg::ST_MIN : v);
        return c[fdl_pkg::STATE_W-1:0];
    endfunction

    fdl_pkg::t_coefs     w_coefs;
    logic [IDX_W-1:0]    w_dist;
    logic                w_cfg_busy;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [IDX_W-1:0]    r_wi;
    logic                r_full;
    logic                r_zero;
    logic                r_rd_ok;
    logic                r_out_valid;
    logic [S-1:0]        r_out;

    logic signed [S-1:0]                  r_x;
    logic signed [S-1:0]                  r_w;
    logic signed [S-1:0]                  r_y;
    logic signed [fdl_pkg::STATE_W-1:0]   r_s1;
    logic signed [fdl_pkg::STATE_W-1:0]   r_s2;
    logic signed [S+16:0]                 r_p_gd;
    logic signed [S+17:0]                 r_p_dry;
    logic signed [S+17:0]                 r_p_my;
    logic signed [S+23:0]                 r_p_b0;
    logic signed [S+23:0]                 r_p_b1;
    logic signed [S+23:0]                 r_p_b2;
    logic signed [S+23:0]                 r_p_a1;
    logic signed [S+23:0]                 r_p_a2;

    logic                w_in_acc;
    logic                w_out_free;
    logic [IDX_W:0]      w_diff;
    logic [IDX_W:0]      w_wrap;
    logic [IDX_W-1:0]    w_ri;
    logic [S-1:0]        w_rdata;
    logic signed [S-1:0] w_d;
    logic [16:0]         w_dry_k;
    logic signed [63:0]  e_x, e_gd, e_dry, e_my, e_b0, e_b1, e_b2, e_a1, e_a2, e_s1, e_s2;
    logic signed [S-1:0] w_wet;
    logic signed [S-1:0] w_y;
    logic signed [S-1:0] w_out;
    logic signed [fdl_pkg::STATE_W-1:0] w_s1;
    logic signed [fdl_pkg::STATE_W-1:0] w_s2;

    fdl_cfg #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (w_coefs),
        .o_dist      (w_dist),
        .o_busy      (w_cfg_busy)
    );

    // read address: write index minus distance, wrapped
    assign w_diff = {1'b0, r_wi} - {1'b0, w_dist};
    assign w_wrap = w_diff + DEPTH_X;
    assign w_ri   = w_diff[IDX_W] ? w_wrap[IDX_W-1:0] : w_diff[IDX_W-1:0];

    fdl_mem #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (S)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_A),
        .i_waddr (r_wi),
        .i_wdata (r_y),
        .i_re    (w_in_acc),
        .i_raddr (w_ri),
        .o_rdata (w_rdata)
    );

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE) && !w_cfg_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    // delayed operand: input itself at zero distance, zero for unwritten entries
    assign w_d = r_zero ? r_x : (r_rd_ok ? $signed(w_rdata) : '0);
    assign w_dry_k = 17'h10000 - {1'b0, w_coefs.mix};

    // sign extension of the product registers
    assign e_x   = 64'(r_x);
    assign e_gd  = 64'(r_p_gd);
    assign e_dry = 64'(r_p_dry);
    assign e_my  = 64'(r_p_my);
    assign e_b0  = 64'(r_p_b0);
    assign e_b1  = 64'(r_p_b1);
    assign e_b2  = 64'(r_p_b2);
    assign e_a1  = 64'(r_p_a1);
    assign e_a2  = 64'(r_p_a2);
    assign e_s1  = 64'(r_s1);
    assign e_s2  = 64'(r_s2);

    // rounding, shifting and saturation
    assign w_wet = sat_smp(e_x + ((e_gd + fdl_pkg::RND_15) >>> 15));
    assign w_y   = sat_smp((e_b0 + e_s1 + fdl_pkg::RND_19) >>> 20);
    assign w_s1  = sat_st(e_b1 - e_a1 + e_s2);
    assign w_s2  = sat_st(e_b2 - e_a2);
    assign w_out = sat_smp((e_dry + e_my + fdl_pkg::RND_16) >>> 16);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_RD;
            ST_RD:   n_state = ST_W;
            ST_W:    n_state = ST_B;
            ST_B:    n_state = ST_Y;
            ST_Y:    n_state = ST_A;
            ST_A:    n_state = ST_S;
            ST_S:    if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wi        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_s1        <= '0;
            r_s2        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_A) begin
                if (r_wi == WI_LAST) begin
                    r_wi   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wi <= r_wi + IDX_W'(1);
                end
            end
            if (r_state == ST_S && w_out_free) begin
                r_out_valid <= 1'b1;
                r_s1        <= w_s1;
                r_s2        <= w_s2;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x     <= $signed(s_axis_tdata[S-1:0]);
            r_zero  <= (w_dist == '0);
            r_rd_ok <= r_full || (w_ri < r_wi);
        end
        if (r_state == ST_RD) begin
            r_p_gd  <= $signed({1'b0, w_coefs.gain}) * w_d;
            r_p_dry <= $signed({1'b0, w_dry_k}) * r_x;
        end
        if (r_state == ST_W) begin
            r_w <= w_wet;
        end
        if (r_state == ST_B) begin
            r_p_b0 <= $signed(w_coefs.b0) * r_w;
            r_p_b1 <= $signed(w_coefs.b1) * r_w;
            r_p_b2 <= $signed(w_coefs.b2) * r_w;
        end
        if (r_state == ST_Y) begin
            r_y <= w_y;
        end
        if (r_state == ST_A) begin
            r_p_a1 <= $signed(w_coefs.a1) * r_y;
            r_p_a2 <= $signed(w_coefs.a2) * r_y;
            r_p_my <= $signed({1'b0, w_coefs.mix, 1'b0}) * r_y;
        end
        if (r_state == ST_S && w_out_free) begin
            r_out <= w_out;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == ST_RD)
        else $error("accepted beat did not start a memory read");

    a_index_moves_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wi != $past(r_wi) |-> $past(r_state) == ST_A)
        else $error("write index moved outside the write-back step");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("fill flag dropped without reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_S && m_axis_tvalid && !m_axis_tready
        |=> r_state == ST_S && $stable(m_axis_tdata))
        else $error("pending result overwritten");

    a_no_input_while_reducing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_busy |-> !s_axis_tready)
        else $error("input taken while delay distance is being reduced");
`endif

endmodule
